### hdl/mcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_pkg: shared types, constants and tables of the month calendar grid
// Holds the queue entry type, the Zeller constants and the month tables.
// ----------------------------------------------------------------------------
package mcg_pkg;

  // Input and output field widths.
  localparam int YearW  = 14;
  localparam int MonthW = 4;
  localparam int DayW   = 5;

  // Internal widths.
  localparam int ShiftYearW = 15;  // year plus 400 reaches 16783
  localparam int CellW      = 6;   // grid cell index, 0..41
  localparam int ColW       = 3;   // weekday column, 0..6
  localparam int SumW       = 11;  // Zeller sum before the mod 7, up to 1038

  // Month range.
  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  // Divide by 100: multiply by 5243 and shift right by 19 (exact up to 16783).
  localparam logic [12:0] CentRecip = 13'd5243;
  localparam int          CentShift = 19;
  // Divide by 7: multiply by 2341 and shift right by 14 (exact up to 1038).
  localparam logic [11:0] WeekRecip = 12'd2341;
  localparam int          WeekShift = 14;

  // Last column of a row (Saturday) and the last cell index of 4, 5 and 6 rows.
  localparam logic [ColW-1:0]  LastCol     = 3'd6;
  localparam logic [CellW-1:0] LastCell4   = 6'd27;
  localparam logic [CellW-1:0] LastCell5   = 6'd34;
  localparam logic [CellW-1:0] LastCell6   = 6'd41;
  localparam logic [CellW-1:0] FourRowSpan = 6'd28;
  localparam logic [CellW-1:0] FiveRowSpan = 6'd35;

  // Default depth of the queue between front and back.
  localparam int QueueDepthDef = 2;

  // One laid-out month waiting for the back part.
  typedef struct packed {
    logic [ColW-1:0] lead;  // weekday of day 1, 0 is Sunday
    logic [DayW-1:0] len;   // days in the month
  } mcg_entry_t;

  // Write request from the front part into the queue.
  typedef struct packed {
    logic       valid;
    mcg_entry_t entry;
  } mcg_push_t;

  // Days in a month of a common year.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month);
    logic [DayW-1:0] len;
    case (month)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // Month term floor(26 * (m + 1) / 10), with January and February as 13 and 14.
  function automatic logic [5:0] month_term(input logic [MonthW-1:0] month);
    logic [5:0] term;
    case (month)
      4'd1:    term = 6'd36;
      4'd2:    term = 6'd39;
      4'd3:    term = 6'd10;
      4'd4:    term = 6'd13;
      4'd5:    term = 6'd15;
      4'd6:    term = 6'd18;
      4'd7:    term = 6'd20;
      4'd8:    term = 6'd23;
      4'd9:    term = 6'd26;
      4'd10:   term = 6'd28;
      4'd11:   term = 6'd31;
      4'd12:   term = 6'd33;
      default: term = 6'd0;
    endcase
    return term;
  endfunction

endpackage

### hdl/mcg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_front: weekday and month length of each requested month
// A three-stage pipeline: shift the year, divide by 100, form the Zeller sum
// and the month length. The mod 7 is taken on the way into the queue.
// ----------------------------------------------------------------------------
module mcg_front
  import mcg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [YearW-1:0]  in_year,
  input  logic [MonthW-1:0] in_month,
  output mcg_push_t         q_push,
  input  logic              q_full
);

  logic                  adv;
  logic                  month_ok;
  logic [ShiftYearW-1:0] yy_in;

  logic                  v1_r, v2_r, v3_r;
  logic [ShiftYearW-1:0] yy1_r, yy2_r;
  logic [MonthW-1:0]     month1_r, month2_r;
  logic [27:0]           prod2_r;
  logic [SumW-1:0]       sum3_r;
  logic [DayW-1:0]       len3_r;

  logic [7:0]            cent2;
  logic [ShiftYearW-1:0] rem_full;
  logic [6:0]            rem2;
  logic [11:0]           cent_term;
  logic [8:0]            rem_term;
  logic [SumW-1:0]       sum_nxt;
  logic [6:0]            rem_y;
  logic [1:0]            cent_y;
  logic                  leap;
  logic [DayW-1:0]       len_nxt;
  logic [22:0]           week_prod;
  logic [7:0]            weeks;
  logic [SumW-1:0]       lead_full;

  // The whole pipeline holds while its last stage waits on a full queue.
  assign adv     = !(v3_r && q_full);
  assign in_full = !adv;

  // Months outside 1..12 give no cells and are dropped here.
  assign month_ok = (in_month >= MonthJan) && (in_month <= MonthDec);
  assign yy_in    = (in_month <= MonthFeb) ? ShiftYearW'(in_year) + 15'd399
                                           : ShiftYearW'(in_year) + 15'd400;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_push && month_ok;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Century and remainder of the shifted year, Zeller sum and leap rule.
  always_comb begin
    cent2     = prod2_r[CentShift+7:CentShift];
    rem_full  = yy2_r - ShiftYearW'(16'(cent2) * 16'd100);
    rem2      = rem_full[6:0];
    cent_term = (12'(cent2) * 12'd21) >> 2;
    rem_term  = (9'(rem2) * 9'd5) >> 2;
    sum_nxt   = SumW'(cent_term) + SumW'(rem_term) + SumW'(month_term(month2_r));
    // For February the shifted year is the year plus 399; step back to the year.
    rem_y     = (rem2 == 7'd99) ? 7'd0 : rem2 + 7'd1;
    cent_y    = cent2[1:0] + ((rem2 == 7'd99) ? 2'd1 : 2'd0);
    leap      = ((rem_y != 7'd0) && (rem_y[1:0] == 2'd0)) ||
                ((rem_y == 7'd0) && (cent_y == 2'd0));
    len_nxt   = month_len(month2_r) +
                (((month2_r == MonthFeb) && leap) ? 5'd1 : 5'd0);
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      yy1_r    <= yy_in;
      month1_r <= in_month;
      prod2_r  <= 28'(yy1_r) * 28'(CentRecip);
      yy2_r    <= yy1_r;
      month2_r <= month1_r;
      sum3_r   <= sum_nxt;
      len3_r   <= len_nxt;
    end
  end

  // Weekday of day 1 is the Zeller sum mod 7.
  always_comb begin
    week_prod          = 23'(sum3_r) * 23'(WeekRecip);
    weeks              = week_prod[WeekShift+7:WeekShift];
    lead_full          = sum3_r - SumW'(11'(weeks) * 11'd7);
    q_push.valid       = v3_r;
    q_push.entry.lead  = lead_full[ColW-1:0];
    q_push.entry.len   = len3_r;
  end

endmodule

### hdl/mcg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_queue: short queue of laid-out months
// Circular buffer between the front and back parts.
// ----------------------------------------------------------------------------
module mcg_queue
  import mcg_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  mcg_push_t  q_push,
  output logic       q_full,
  input  logic       q_pop,
  output logic       q_empty,
  output mcg_entry_t q_head
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  mcg_entry_t      store_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            wr_en, rd_en;

  assign q_full  = (count_r == FullCnt);
  assign q_empty = (count_r == '0);
  assign wr_en   = q_push.valid && !q_full;
  assign rd_en   = q_pop && !q_empty;
  assign q_head  = store_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + CntW'(1);
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - CntW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_ptr_r] <= q_push.entry;
    end
  end

endmodule

### hdl/mcg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_back: cell sequencer of the grid
// Walks the cells of one month, one cell per item taken, and loads the next
// month from the queue as the last cell leaves.
// ----------------------------------------------------------------------------
module mcg_back
  import mcg_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  mcg_entry_t      q_head,
  output logic            q_pop,
  output logic            empty,
  input  logic            pop,
  output logic [DayW-1:0] out_day_number,
  output logic            out_row_end,
  output logic            out_last
);

  logic             active_r;
  logic [CellW-1:0] cell_r;
  logic [ColW-1:0]  col_r;
  logic [ColW-1:0]  lead_r;
  logic [DayW-1:0]  len_r;
  logic [CellW-1:0] last_idx_r;

  logic             at_last;
  logic             take;
  logic             load;
  logic [CellW-1:0] span;
  logic [CellW-1:0] last_idx_nxt;
  logic [CellW-1:0] offs;

  assign empty   = !active_r;
  assign at_last = (cell_r == last_idx_r);
  assign take    = pop && active_r;
  assign load    = !q_empty && (!active_r || (take && at_last));
  assign q_pop   = load;

  // Grid length in whole weeks: four, five or six rows.
  always_comb begin
    span = CellW'(q_head.lead) + CellW'(q_head.len);
    if (span <= FourRowSpan) begin
      last_idx_nxt = LastCell4;
    end else if (span <= FiveRowSpan) begin
      last_idx_nxt = LastCell5;
    end else begin
      last_idx_nxt = LastCell6;
    end
  end

  // Cell counter and month registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cell_r   <= '0;
      col_r    <= '0;
    end else if (load) begin
      active_r <= 1'b1;
      cell_r   <= '0;
      col_r    <= '0;
    end else if (take) begin
      if (at_last) begin
        active_r <= 1'b0;
      end else begin
        cell_r <= cell_r + CellW'(1);
        col_r  <= (col_r == LastCol) ? '0 : col_r + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lead_r     <= q_head.lead;
      len_r      <= q_head.len;
      last_idx_r <= last_idx_nxt;
    end
  end

  // Day in the current cell, blank before day 1 and after the last day.
  always_comb begin
    offs = cell_r - CellW'(lead_r);
    if ((cell_r >= CellW'(lead_r)) && (offs < CellW'(len_r))) begin
      out_day_number = offs[DayW-1:0] + DayW'(1);
    end else begin
      out_day_number = '0;
    end
    out_row_end = (col_r == LastCol);
    out_last    = at_last;
  end

endmodule

### hdl/month_calendar_grid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// month_calendar_grid: Sunday-first calendar grid of one Gregorian month
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------------
//   input    | push / full        | in_year, in_month
//   result   | pop / empty        | out_day_number, out_row_end, out_last
//
// Each month in 1..12 gives 28, 35 or 42 cells, one per cycle while pop is
// high; the back cell counter sets that rate. A push passes the front stages
// and the queue before its first cell. Months outside 1..12 give no cells.
// The front and back stall apart through a QUEUE_DEPTH-entry queue.
// Reset is synchronous and leaves the block empty.
// ----------------------------------------------------------------------------
module month_calendar_grid
  import mcg_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [YearW-1:0]  in_year,
  input  logic [MonthW-1:0] in_month,
  output logic              empty,
  input  logic              pop,
  output logic [DayW-1:0]   out_day_number,
  output logic              out_row_end,
  output logic              out_last
);

  mcg_push_t  q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  mcg_entry_t q_head;

  // Weekday and month length.
  mcg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (push),
    .in_full  (full),
    .in_year  (in_year),
    .in_month (in_month),
    .q_push   (q_push),
    .q_full   (q_full)
  );

  // Queue between the two parts.
  mcg_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  // Cell sequencer.
  mcg_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_day_number (out_day_number),
    .out_row_end    (out_row_end),
    .out_last       (out_last)
  );

  // The grid always ends on a Saturday.
  a_last_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_last) |-> out_row_end)
    else $error("last cell of a grid is not in the Saturday column");

  // The final cell is blank or holds the last day of a month.
  a_last_day: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_last) |-> (out_day_number == 5'd0 || out_day_number >= 5'd28))
    else $error("final cell holds a day that cannot end a month");

  // A queue entry is only taken by the back part when it is present.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("back part took an item from an empty queue");

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result side not empty after reset");

endmodule
